### rtl/bcfb_pkg.sv
// Shared types, register and format codes and pixel helpers for the
// centered bitmap blit core. No dependencies.
`default_nettype none

package bcfb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FMT_W      = 2;
  localparam int PIX_W      = 24;
  localparam int IDX_W      = 24;
  localparam int ARGB_W     = 32;

  localparam logic [CFG_DATA_W-1:0] SOURCE_WIDTH_RST  = 13'd1280;
  localparam logic [CFG_DATA_W-1:0] SOURCE_HEIGHT_RST = 13'd720;
  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST   = 13'd1280;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST  = 13'd720;

  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
  localparam logic [15:0] RGB565_R_MASK = 16'hF800;
  localparam logic [15:0] RGB565_G_MASK = 16'h07E0;
  localparam logic [15:0] RGB565_B_MASK = 16'h001F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_FRAME_WIDTH   = 3'd2,
    REG_FRAME_HEIGHT  = 3'd3,
    REG_PIXEL_FORMAT  = 3'd4
  } reg_index_t;

  typedef enum logic [FMT_W-1:0] {
    FMT_BGR24  = 2'd0,
    FMT_RGB565 = 2'd1
  } pix_fmt_t;

  // Per-stage status that moves down the pipeline with each transaction
  typedef struct packed {
    logic vld;
    logic done;
    logic hit;
  } stage_flags_t;

  // RGB565 to 24-bit RGB, the low bits of each channel repeated below it
  function automatic logic [23:0] expand565(input logic [15:0] p);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    r = 5'((p & RGB565_R_MASK) >> 11);
    g = 6'((p & RGB565_G_MASK) >> 5);
    b = 5'(p & RGB565_B_MASK);
    return {r, r[2:0], g, g[1:0], b, b[2:0]};
  endfunction

endpackage

`default_nettype wire

### rtl/bcfb_cfg.sv
// Configuration registers, dimension clamping and registered window geometry.
// Depends on bcfb_pkg.
`default_nettype none

module bcfb_cfg #(
  parameter int MAX_DIMENSION = 4096,
  parameter int DW = $clog2(MAX_DIMENSION + 1),
  parameter int CW = $clog2(MAX_DIMENSION)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcfb_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [DW-1:0]                        src_w,
  output logic [DW-1:0]                        src_h,
  output logic [DW-1:0]                        sxs_r,
  output logic [DW-1:0]                        sxe_r,
  output logic [DW-1:0]                        sys_r,
  output logic [DW-1:0]                        sye_r,
  output logic [CW-1:0]                        base_col_r,
  output logic [CW-1:0]                        base_row_r,
  output logic [DW-1:0]                        frm_w_r,
  output logic [bcfb_pkg::FMT_W-1:0]           fmt
);
  import bcfb_pkg::*;

  logic [CFG_DATA_W-1:0] source_width_r;
  logic [CFG_DATA_W-1:0] source_height_r;
  logic [CFG_DATA_W-1:0] frame_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;
  logic [FMT_W-1:0]      pixel_format_r;

  logic [DW-1:0] frm_w;
  logic [DW-1:0] frm_h;
  logic [DW-1:0] sxs_nxt, sxe_nxt, dxs;
  logic [DW-1:0] sys_nxt, sye_nxt, dys, dye;
  logic [CW-1:0] base_col_nxt, base_row_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= SOURCE_WIDTH_RST;
      source_height_r <= SOURCE_HEIGHT_RST;
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      pixel_format_r  <= FMT_BGR24;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width_r  <= cfg_data;
        REG_SOURCE_HEIGHT: source_height_r <= cfg_data;
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        REG_PIXEL_FORMAT:  pixel_format_r  <= cfg_data[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero reads as one, anything above the maximum as the maximum
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    logic [DW-1:0] res;
    if (v == '0) begin
      res = DW'(1);
    end else if (32'(v) > MAX_DIMENSION) begin
      res = DW'(MAX_DIMENSION);
    end else begin
      res = DW'(v);
    end
    return res;
  endfunction

  assign src_w = clamp_dim(source_width_r);
  assign src_h = clamp_dim(source_height_r);
  assign frm_w = clamp_dim(frame_width_r);
  assign frm_h = clamp_dim(frame_height_r);
  assign fmt   = pixel_format_r;

  // Center each axis: crop a larger source, pad around a smaller one
  always_comb begin
    if (frm_w <= src_w) begin
      sxs_nxt = (src_w - frm_w) >> 1;
      sxe_nxt = sxs_nxt + frm_w;
      dxs     = '0;
    end else begin
      sxs_nxt = '0;
      sxe_nxt = src_w;
      dxs     = (frm_w - src_w) >> 1;
    end
    if (frm_h <= src_h) begin
      sys_nxt = (src_h - frm_h) >> 1;
      sye_nxt = sys_nxt + frm_h;
      dys     = '0;
      dye     = frm_h;
    end else begin
      sys_nxt = '0;
      sye_nxt = src_h;
      dys     = (frm_h - src_h) >> 1;
      dye     = dys + src_h;
    end
    // Row flip folds into one base: drow = (dye - 1 + sys) - row
    base_row_nxt = CW'(dye) - CW'(1) + CW'(sys_nxt);
    base_col_nxt = CW'(dxs) - CW'(sxs_nxt);
  end

  always_ff @(posedge clk) begin
    sxs_r      <= sxs_nxt;
    sxe_r      <= sxe_nxt;
    sys_r      <= sys_nxt;
    sye_r      <= sye_nxt;
    base_col_r <= base_col_nxt;
    base_row_r <= base_row_nxt;
    frm_w_r    <= frm_w;
  end

endmodule

`default_nettype wire

### rtl/bcfb_scan.sv
// Column and row counters plus the input register stage.
// Depends on bcfb_pkg.
`default_nettype none

module bcfb_scan #(
  parameter int MAX_DIMENSION = 4096,
  parameter int DW = $clog2(MAX_DIMENSION + 1),
  parameter int CW = $clog2(MAX_DIMENSION)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic                       s1_adv,
  input  wire logic [bcfb_pkg::PIX_W-1:0] pixel,
  input  wire logic [DW-1:0]              src_w,
  input  wire logic [DW-1:0]              src_h,
  output bcfb_pkg::stage_flags_t          s1_flags,
  output logic [CW-1:0]                   s1_col_r,
  output logic [CW-1:0]                   s1_row_r,
  output logic [bcfb_pkg::PIX_W-1:0]      s1_pix_r
);
  import bcfb_pkg::*;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          wrap_col, wrap_row, done;
  logic          s1_vld_r, s1_done_r;

  // A counter at or past the size wraps as though it were the last one
  assign wrap_col = ((DW + 1)'(col_r) + (DW + 1)'(1)) >= (DW + 1)'(src_w);
  assign wrap_row = ((DW + 1)'(row_r) + (DW + 1)'(1)) >= (DW + 1)'(src_h);
  assign done     = wrap_col && wrap_row;

  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (wrap_col) begin
      col_nxt = '0;
      row_nxt = wrap_row ? '0 : row_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (s1_adv) begin
        s1_vld_r <= accept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_pix_r  <= pixel;
      s1_done_r <= done;
    end
  end

  assign s1_flags.vld  = s1_vld_r;
  assign s1_flags.done = s1_done_r;
  assign s1_flags.hit  = 1'b0;

  a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done |=> col_r == '0 && row_r == '0)
    else $error("counters did not restart after the last pixel");

endmodule

`default_nettype wire

### rtl/bcfb_map.sv
// Window test, flipped destination row, destination column and ARGB conversion stage.
// Depends on bcfb_pkg.
`default_nettype none

module bcfb_map #(
  parameter int MAX_DIMENSION = 4096,
  parameter int DW = $clog2(MAX_DIMENSION + 1),
  parameter int CW = $clog2(MAX_DIMENSION)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s2_adv,
  input  bcfb_pkg::stage_flags_t           s1_flags,
  input  wire logic [CW-1:0]               s1_col,
  input  wire logic [CW-1:0]               s1_row,
  input  wire logic [bcfb_pkg::PIX_W-1:0]  s1_pix,
  input  wire logic [DW-1:0]               sxs,
  input  wire logic [DW-1:0]               sxe,
  input  wire logic [DW-1:0]               sys,
  input  wire logic [DW-1:0]               sye,
  input  wire logic [CW-1:0]               base_col,
  input  wire logic [CW-1:0]               base_row,
  input  wire logic [bcfb_pkg::FMT_W-1:0]  fmt,
  output bcfb_pkg::stage_flags_t           s2_flags,
  output logic [CW-1:0]                    s2_dcol_r,
  output logic [CW-1:0]                    s2_drow_r,
  output logic [bcfb_pkg::ARGB_W-1:0]      s2_argb_r
);
  import bcfb_pkg::*;

  logic              in_win, fmt_ok, hit;
  logic [23:0]       rgb;
  logic              s2_vld_r, s2_done_r, s2_hit_r;

  assign in_win = (DW'(s1_col) >= sxs) && (DW'(s1_col) < sxe) &&
                  (DW'(s1_row) >= sys) && (DW'(s1_row) < sye);
  assign fmt_ok = (fmt == FMT_BGR24) || (fmt == FMT_RGB565);
  assign hit    = in_win && fmt_ok;
  assign rgb    = (fmt == FMT_BGR24) ? s1_pix : expand565(s1_pix[15:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_adv) begin
      s2_vld_r <= s1_flags.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_done_r <= s1_flags.done;
      s2_hit_r  <= hit;
      s2_dcol_r <= s1_col + base_col;
      s2_drow_r <= base_row - s1_row;
      s2_argb_r <= {ALPHA_OPAQUE, rgb};
    end
  end

  assign s2_flags.vld  = s2_vld_r;
  assign s2_flags.done = s2_done_r;
  assign s2_flags.hit  = s2_hit_r;

endmodule

`default_nettype wire

### rtl/bcfb_emit.sv
// Word index multiply-add and the output register.
// Depends on bcfb_pkg.
`default_nettype none

module bcfb_emit #(
  parameter int MAX_DIMENSION = 4096,
  parameter int DW = $clog2(MAX_DIMENSION + 1),
  parameter int CW = $clog2(MAX_DIMENSION)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        out_adv,
  input  bcfb_pkg::stage_flags_t           s2_flags,
  input  wire logic [CW-1:0]               s2_dcol,
  input  wire logic [CW-1:0]               s2_drow,
  input  wire logic [bcfb_pkg::ARGB_W-1:0] s2_argb,
  input  wire logic [DW-1:0]               frm_w,
  output logic                             out_vld_r,
  output logic                             out_write_valid_r,
  output logic [bcfb_pkg::IDX_W-1:0]       out_word_index_r,
  output logic [bcfb_pkg::ARGB_W-1:0]      out_argb_value_r,
  output logic                             out_frame_done_r
);
  import bcfb_pkg::*;

  localparam int PW   = CW + DW;
  localparam int SUMW = (PW > IDX_W) ? PW : IDX_W;

  logic [PW-1:0]   prod;
  logic [SUMW-1:0] sum;

  assign prod = PW'(s2_drow) * PW'(frm_w);
  assign sum  = SUMW'(prod) + SUMW'(s2_dcol);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= s2_flags.vld;
    end
  end

  // Outside the window, or in an unsupported format: zero payload
  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_write_valid_r <= s2_flags.hit;
      out_frame_done_r  <= s2_flags.done;
      out_word_index_r  <= s2_flags.hit ? sum[IDX_W-1:0] : '0;
      out_argb_value_r  <= s2_flags.hit ? s2_argb : '0;
    end
  end

endmodule

`default_nettype wire

### rtl/bitmap_center_crop_flip_blit_core.sv
// Centered bitmap-to-framebuffer blit core, top level.
// Depends on bcfb_pkg, bcfb_cfg, bcfb_scan, bcfb_map and bcfb_emit.
//
// Usage:
//   Source pixels enter on the in_ channel in bitmap file order, one per
//   transaction (valid/stall). Each pixel yields exactly one result on the
//   out_ channel: a write flag, the destination word index (rows flipped),
//   the ARGB8888 value and a frame-done flag on the last pixel of the bitmap.
//   Geometry and pixel format are set through the cfg_ port (valid/ready,
//   always ready); write it only while no transaction is in flight.
//   An accepted pixel passes the input stage, the window/color stage and
//   the output register. Throughput: one pixel per clock while out_stall
//   is low, set by the three register stages (input, window/color, index
//   multiply-add) each taking a new transaction every cycle.
//   Receiver stall: the output register holds its result; the stages behind
//   keep filling empty slots, and in_stall rises only once all three stages
//   hold data, so up to three transactions sit in the pipe.
//   Reset (synchronous, rst_n low) empties the pipe, clears the column and
//   row counters and loads 1280x720 source and frame sizes in BGR24 format.
`default_nettype none

module bitmap_center_crop_flip_blit_core #(
  parameter int MAX_DIMENSION = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [bcfb_pkg::PIX_W-1:0]      in_source_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_write_valid,
  output logic [bcfb_pkg::IDX_W-1:0]           out_word_index,
  output logic [bcfb_pkg::ARGB_W-1:0]          out_argb_value,
  output logic                                 out_frame_done,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bcfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcfb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bcfb_pkg::*;

  localparam int DW = $clog2(MAX_DIMENSION + 1);
  localparam int CW = $clog2(MAX_DIMENSION);

  logic [DW-1:0]    src_w, src_h;
  logic [DW-1:0]    sxs, sxe, sys, sye, frm_w;
  logic [CW-1:0]    base_col, base_row;
  logic [FMT_W-1:0] fmt;

  stage_flags_t      s1_flags, s2_flags;
  logic [CW-1:0]     s1_col, s1_row, s2_dcol, s2_drow;
  logic [PIX_W-1:0]  s1_pix;
  logic [ARGB_W-1:0] s2_argb;

  logic accept, s1_adv, s2_adv, out_adv;

  // A stage advances when it is empty or the next one advances
  assign out_adv  = !out_valid || !out_stall;
  assign s2_adv   = !s2_flags.vld || out_adv;
  assign s1_adv   = !s1_flags.vld || s2_adv;
  assign in_stall = !s1_adv;
  assign accept   = in_valid && !in_stall;

  bcfb_cfg #(
    .MAX_DIMENSION(MAX_DIMENSION),
    .DW(DW),
    .CW(CW)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .src_w      (src_w),
    .src_h      (src_h),
    .sxs_r      (sxs),
    .sxe_r      (sxe),
    .sys_r      (sys),
    .sye_r      (sye),
    .base_col_r (base_col),
    .base_row_r (base_row),
    .frm_w_r    (frm_w),
    .fmt        (fmt)
  );

  bcfb_scan #(
    .MAX_DIMENSION(MAX_DIMENSION),
    .DW(DW),
    .CW(CW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .s1_adv   (s1_adv),
    .pixel    (in_source_pixel),
    .src_w    (src_w),
    .src_h    (src_h),
    .s1_flags (s1_flags),
    .s1_col_r (s1_col),
    .s1_row_r (s1_row),
    .s1_pix_r (s1_pix)
  );

  bcfb_map #(
    .MAX_DIMENSION(MAX_DIMENSION),
    .DW(DW),
    .CW(CW)
  ) u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_adv    (s2_adv),
    .s1_flags  (s1_flags),
    .s1_col    (s1_col),
    .s1_row    (s1_row),
    .s1_pix    (s1_pix),
    .sxs       (sxs),
    .sxe       (sxe),
    .sys       (sys),
    .sye       (sye),
    .base_col  (base_col),
    .base_row  (base_row),
    .fmt       (fmt),
    .s2_flags  (s2_flags),
    .s2_dcol_r (s2_dcol),
    .s2_drow_r (s2_drow),
    .s2_argb_r (s2_argb)
  );

  bcfb_emit #(
    .MAX_DIMENSION(MAX_DIMENSION),
    .DW(DW),
    .CW(CW)
  ) u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_adv           (out_adv),
    .s2_flags          (s2_flags),
    .s2_dcol           (s2_dcol),
    .s2_drow           (s2_drow),
    .s2_argb           (s2_argb),
    .frm_w             (frm_w),
    .out_vld_r         (out_valid),
    .out_write_valid_r (out_write_valid),
    .out_word_index_r  (out_word_index),
    .out_argb_value_r  (out_argb_value),
    .out_frame_done_r  (out_frame_done)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_flags.vld && s2_flags.vld && out_valid && out_stall)
    else $error("input stalled while the pipeline has a free slot");

  a_skip_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_word_index == '0 && out_argb_value == '0)
    else $error("skipped pixel carries a nonzero payload");

  a_alpha_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_argb_value[31:24] == ALPHA_OPAQUE)
    else $error("written pixel is not fully opaque");

endmodule

`default_nettype wire
